[rtl/core/assert_macros.svh]
// Assertion macros shared by the mailbox queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i outside of reset
`define MMQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a consequent holds whenever an antecedent holds
`define MMQ_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/mmq_pkg.sv]
// Types, sizes and codes of the mailbox queue table
package mmq_pkg;

  localparam int NUM_BOXES = 16;
  localparam int BOX_DEPTH = 64;

  localparam int BOX_W  = $clog2(NUM_BOXES);
  localparam int POS_W  = $clog2(BOX_DEPTH);
  localparam int CNT_W  = $clog2(BOX_DEPTH + 1);
  localparam int MSG_AW = BOX_W + POS_W;

  typedef logic [BOX_W-1:0] box_idx_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_SEND  = 2'd1,
    OP_RECV  = 2'd2,
    OP_FREE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_ALLOC = 3'd1,
    ST_NO_BOX    = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // Per-box queue descriptor
  typedef struct packed {
    logic [POS_W-1:0] head;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] limit;
  } desc_t;

  // In-use table update requests
  typedef struct packed {
    logic     set;
    logic     clr;
    box_idx_t clr_idx;
  } alloc_ctl_t;

  // Add two box indexes below NUM_BOXES, wrapping around the table
  function automatic box_idx_t box_wrap_add(box_idx_t a, box_idx_t b);
    logic [BOX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (BOX_W+1)'(NUM_BOXES)) begin
      s = s - (BOX_W+1)'(NUM_BOXES);
    end
    return s[BOX_W-1:0];
  endfunction

endpackage

[rtl/core/mmq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data
module mmq_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/mmq_alloc.sv]
// In-use bits, round-robin search pointer and free-box search
module mmq_alloc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmq_pkg::alloc_ctl_t ctl_i,
  output logic [mmq_pkg::NUM_BOXES-1:0] in_use_o,
  output logic                found_o,
  output mmq_pkg::box_idx_t   pick_o
);
  import mmq_pkg::*;

  logic [NUM_BOXES-1:0] in_use_q, in_use_d;
  box_idx_t             sp_q, sp_d;
  logic [NUM_BOXES-1:0] free_rot;
  box_idx_t             base;
  box_idx_t             offset;

  // Rotate the free bits so that position zero is the box after the pointer
  always_comb begin
    base = box_wrap_add(sp_q, BOX_W'(1));
    for (int i = 0; i < NUM_BOXES; i++) begin
      free_rot[i] = !in_use_q[box_wrap_add(base, BOX_W'(i))];
    end
  end

  always_comb begin
    offset = '0;
    for (int i = NUM_BOXES - 1; i >= 0; i--) begin
      if (free_rot[i]) begin
        offset = BOX_W'(i);
      end
    end
  end

  assign found_o = |free_rot;
  assign pick_o  = box_wrap_add(base, offset);

  always_comb begin
    in_use_d = in_use_q;
    sp_d     = sp_q;
    if (ctl_i.clr) begin
      in_use_d[ctl_i.clr_idx] = 1'b0;
    end
    if (ctl_i.set) begin
      in_use_d[pick_o] = 1'b1;
      sp_d             = pick_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      sp_q     <= '0;
    end else begin
      in_use_q <= in_use_d;
      sp_q     <= sp_d;
    end
  end

  assign in_use_o = in_use_q;

endmodule

[rtl/core/multi_mailbox_queue_table_core.sv]
// Top level of the mailbox queue table: command sequencer and memories
//
// A table of mailboxes, each a circular queue of 32-bit words with the
// capacity given at allocate time. A command is taken when start_i is high
// and busy_o is low. Allocate, send and free give their result after the
// synchronous read of the box descriptor memory in state S_DESC. Receive
// gives it after that read and then the synchronous read of the message
// memory in state S_READ, whose word goes to read_data_o. The result
// is on the output ports for one cycle, marked by done_o, and the receiver
// cannot stall it; busy_o drops in that same cycle, so the next command may
// be issued alongside the result. Neither memory is cleared at reset: a
// descriptor is only used while its in-use bit (cleared by reset) is set, and
// a receive only reads words written since the box was allocated.
module multi_mailbox_queue_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  box_i,
  input  logic [6:0]  capacity_i,
  input  logic signed [31:0] message_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [3:0]  box_index_o,
  output logic signed [31:0] read_data_o,
  output logic [6:0]  queued_o,
  output logic        arrived_flag_o
);
  import mmq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DESC,
    S_READ
  } state_e;

  state_e      state_q, state_d;
  op_e         op_q;
  logic [3:0]  box_q;
  logic [6:0]  cap_q;
  logic [31:0] msg_q;

  logic        done_q, done_d;
  status_e     status_q, status_d;
  logic [3:0]  box_index_q, box_index_d;
  logic [31:0] read_data_q;
  logic [6:0]  queued_q, queued_d;
  logic        arrived_q, arrived_d;

  logic        accept;
  box_idx_t    idx;
  logic        in_range;
  logic        valid;

  logic        desc_we;
  box_idx_t    desc_waddr;
  desc_t       desc_wdata;
  desc_t       desc_rdata;
  logic [$bits(desc_t)-1:0] desc_rdata_raw;

  logic              msg_we, msg_re;
  logic [MSG_AW-1:0] msg_waddr, msg_raddr;
  logic [31:0]       msg_rdata;

  alloc_ctl_t           alloc_ctl;
  logic [NUM_BOXES-1:0] in_use;
  logic                 found;
  box_idx_t             pick;

  logic [CNT_W:0]   tail_sum;
  logic [POS_W-1:0] tail_pos;
  logic [CNT_W-1:0] head_inc;
  logic [POS_W-1:0] head_next;
  logic             cap_bad;

  assign accept   = start_i && !busy_o;
  assign idx      = BOX_W'(box_q);
  assign in_range = 32'(box_q) < NUM_BOXES;
  assign valid    = in_range && in_use[idx];
  assign cap_bad  = (cap_q == 7'd0) || (32'(cap_q) > BOX_DEPTH);

  mmq_ram #(
    .DATA_W ($bits(desc_t)),
    .ADDR_W (BOX_W)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (desc_we),
    .waddr_i (desc_waddr),
    .wdata_i (desc_wdata),
    .re_i    (accept),
    .raddr_i (BOX_W'(box_i)),
    .rdata_o (desc_rdata_raw)
  );

  assign desc_rdata = desc_t'(desc_rdata_raw);

  mmq_ram #(
    .DATA_W (32),
    .ADDR_W (MSG_AW)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (msg_we),
    .waddr_i (msg_waddr),
    .wdata_i (msg_q),
    .re_i    (msg_re),
    .raddr_i (msg_raddr),
    .rdata_o (msg_rdata)
  );

  mmq_alloc u_alloc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (alloc_ctl),
    .in_use_o (in_use),
    .found_o  (found),
    .pick_o   (pick)
  );

  // Tail slot: head plus fill, wrapped once by the box capacity
  always_comb begin
    tail_sum = (CNT_W+1)'(desc_rdata.head) + (CNT_W+1)'(desc_rdata.fill);
    if (tail_sum >= (CNT_W+1)'(desc_rdata.limit)) begin
      tail_sum = tail_sum - (CNT_W+1)'(desc_rdata.limit);
    end
    tail_pos = POS_W'(tail_sum);
    head_inc = CNT_W'(desc_rdata.head) + CNT_W'(1);
    if (head_inc >= desc_rdata.limit) begin
      head_next = '0;
    end else begin
      head_next = POS_W'(head_inc);
    end
  end

  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    status_d    = status_q;
    box_index_d = box_index_q;
    queued_d    = queued_q;
    arrived_d   = arrived_q;
    desc_we     = 1'b0;
    desc_waddr  = idx;
    desc_wdata  = desc_rdata;
    msg_we      = 1'b0;
    msg_waddr   = {idx, tail_pos};
    msg_re      = 1'b0;
    msg_raddr   = {idx, desc_rdata.head};
    alloc_ctl   = '{set: 1'b0, clr: 1'b0, clr_idx: idx};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DESC;
        end
      end
      S_DESC: begin
        state_d     = S_IDLE;
        done_d      = 1'b1;
        status_d    = ST_OK;
        box_index_d = box_q;
        queued_d    = valid ? 7'(desc_rdata.fill) : 7'd0;
        if (op_q == OP_ALLOC) begin
          if (cap_bad || !found) begin
            status_d = ST_NO_BOX;
          end else begin
            alloc_ctl.set = 1'b1;
            desc_we       = 1'b1;
            desc_waddr    = pick;
            desc_wdata    = '{head: '0, fill: '0, limit: CNT_W'(cap_q)};
            box_index_d   = 4'(pick);
            queued_d      = 7'd0;
          end
        end else if (!valid) begin
          status_d = ST_NOT_ALLOC;
        end else begin
          unique case (op_q)
            OP_SEND: begin
              if (desc_rdata.fill >= desc_rdata.limit) begin
                status_d = ST_FULL;
              end else begin
                msg_we          = 1'b1;
                desc_we         = 1'b1;
                desc_wdata.fill = desc_rdata.fill + CNT_W'(1);
                queued_d        = 7'(desc_rdata.fill + CNT_W'(1));
                arrived_d       = 1'b1;
              end
            end
            OP_RECV: begin
              if (desc_rdata.fill == '0) begin
                status_d = ST_EMPTY;
              end else begin
                // Hold the result back for the message read
                msg_re          = 1'b1;
                desc_we         = 1'b1;
                desc_wdata.head = head_next;
                desc_wdata.fill = desc_rdata.fill - CNT_W'(1);
                queued_d        = 7'(desc_rdata.fill - CNT_W'(1));
                arrived_d       = 1'b0;
                done_d          = 1'b0;
                state_d         = S_READ;
              end
            end
            OP_FREE: begin
              alloc_ctl.clr = 1'b1;
              queued_d      = 7'd0;
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      arrived_q   <= 1'b0;
      status_q    <= ST_OK;
      box_index_q <= '0;
      queued_q    <= '0;
      read_data_q <= '0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      arrived_q   <= arrived_d;
      status_q    <= status_d;
      box_index_q <= box_index_d;
      queued_q    <= queued_d;
      if (state_q == S_READ) begin
        read_data_q <= msg_rdata;
      end else if (state_q == S_DESC) begin
        read_data_q <= '0;
      end
    end
  end

  // Capture the command word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(op_i);
      box_q <= box_i;
      cap_q <= capacity_i;
      msg_q <= message_i;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign box_index_o    = box_index_q;
  assign read_data_o    = read_data_q;
  assign queued_o       = queued_q;
  assign arrived_flag_o = arrived_q;

`include "assert_macros.svh"

  `MMQ_ASSERT(a_accept_busy, accept |=> busy_o, "command taken but block not busy")
  `MMQ_ASSERT_IMPL(a_done_after_work, done_o, $past(busy_o), "result without a command")
  `MMQ_ASSERT_IMPL(a_err_no_data, done_o && (status_o != ST_OK), read_data_o == 32'sd0, "read data on error")
  `MMQ_ASSERT_IMPL(a_queued_bound, done_o, 32'(queued_o) <= BOX_DEPTH, "queued count above depth")

endmodule

[tb/sv/mailbox_result_checker.sv]
// Checker for the mailbox queue table: predicts each result word and compares it
module mailbox_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         op_i,
  input  logic [3:0]         box_i,
  input  logic [6:0]         capacity_i,
  input  logic signed [31:0] message_i,
  input  logic               done_i,
  input  logic [2:0]         status_i,
  input  logic [3:0]         box_index_i,
  input  logic signed [31:0] read_data_i,
  input  logic [6:0]         queued_i,
  input  logic               arrived_flag_i,
  output int                 errors_o,
  output int                 outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mmq_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  box;
    logic [31:0] data;
    logic [6:0]  queued;
    logic        arrived;
  } mbox_reply_t;

  mbox_reply_t reply_q[$];

  // Shadow of the mailbox table
  bit               box_used [NUM_BOXES];
  logic [POS_W-1:0] head_at  [NUM_BOXES];
  logic [CNT_W-1:0] fill_cnt [NUM_BOXES];
  logic [CNT_W-1:0] cap_lim  [NUM_BOXES];
  logic [31:0]      msg_mem  [NUM_BOXES][BOX_DEPTH];
  box_idx_t         rr_ptr;
  logic             arrival;

  initial begin
    errors_o = 0;
    outstanding_o = 0;
  end

  task automatic execute_mailbox_cmd(input op_e op, input box_idx_t bx,
                                     input logic [6:0] cap, input logic [31:0] msg,
                                     output mbox_reply_t r);
    int unsigned p;
    int unsigned pos;
    r.status = ST_OK;
    r.box    = bx;
    r.data   = '0;
    if (op == OP_ALLOC) begin
      r.status = ST_NO_BOX;
      if (cap != 0 && cap <= BOX_DEPTH) begin
        p = rr_ptr;
        for (int i = 0; i < NUM_BOXES; i++) begin
          p = (p + 1) % NUM_BOXES;
          if (!box_used[p]) begin
            box_used[p] = 1'b1;
            head_at[p]  = '0;
            fill_cnt[p] = '0;
            cap_lim[p]  = CNT_W'(cap);
            rr_ptr      = box_idx_t'(p);
            r.box       = box_idx_t'(p);
            r.status    = ST_OK;
            break;
          end
        end
      end
    end else if (!box_used[bx]) begin
      r.status = ST_NOT_ALLOC;
    end else if (op == OP_SEND) begin
      if (fill_cnt[bx] >= cap_lim[bx]) begin
        r.status = ST_FULL;
      end else begin
        pos = head_at[bx] + fill_cnt[bx];
        if (pos >= cap_lim[bx]) pos -= cap_lim[bx];
        msg_mem[bx][pos] = msg;
        fill_cnt[bx] = fill_cnt[bx] + 1'b1;
        arrival = 1'b1;
      end
    end else if (op == OP_RECV) begin
      if (fill_cnt[bx] == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.data = msg_mem[bx][head_at[bx]];
        pos = head_at[bx] + 1;
        if (pos >= cap_lim[bx]) pos = 0;
        head_at[bx]  = POS_W'(pos);
        fill_cnt[bx] = fill_cnt[bx] - 1'b1;
        arrival = 1'b0;
      end
    end else begin
      box_used[bx] = 1'b0;
    end
    r.queued  = box_used[r.box] ? 7'(fill_cnt[r.box]) : 7'd0;
    r.arrived = arrival;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    mbox_reply_t want;
    mbox_reply_t got;
    if (!rst_ni) begin
      reply_q.delete();
      for (int b = 0; b < NUM_BOXES; b++) begin
        box_used[b] = 1'b0;
        head_at[b]  = '0;
        fill_cnt[b] = '0;
        cap_lim[b]  = '0;
      end
      rr_ptr = '0;
      arrival = 1'b0;
      outstanding_o = 0;
    end else begin
      // Retire the oldest expectation before taking a new word in the same cycle
      if (done_i) begin
        got.status  = status_i;
        got.box     = box_index_i;
        got.data    = read_data_i;
        got.queued  = queued_i;
        got.arrived = arrived_flag_i;
        if (reply_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result with nothing pending: status %0d box %0d data %h",
                     $realtime, got.status, got.box, got.data);
        end else begin
          want = reply_q.pop_front();
          if (got.status !== want.status || got.box !== want.box ||
              got.data !== want.data || got.queued !== want.queued ||
              got.arrived !== want.arrived) begin
            errors_o++;
            if (errors_o <= 10)
              $display({"%0t: mismatch (expected/actual) status %0d/%0d box %0d/%0d ",
                        "data %h/%h queued %0d/%0d arrived %0b/%0b"}, $realtime,
                       want.status, got.status, want.box, got.box, want.data, got.data,
                       want.queued, got.queued, want.arrived, got.arrived);
          end
        end
      end
      if (start_i && !busy_i) begin
        execute_mailbox_cmd(op_e'(op_i), box_i, capacity_i, message_i, want);
        reply_q.push_back(want);
      end
      outstanding_o = reply_q.size();
    end
  end

endmodule

[tb/sv/multi_mailbox_queue_table_core_test.sv]
// Top of the mailbox queue table testbench: clock, reset, command stimulus and verdict
module multi_mailbox_queue_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mmq_pkg::*;

  localparam int ITEMS          = 1150;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start_i    = 1'b0;
  logic [1:0]         op_i       = '0;
  logic [3:0]         box_i      = '0;
  logic [6:0]         capacity_i = '0;
  logic signed [31:0] message_i  = '0;
  logic               busy_o;
  logic               done_o;
  logic [2:0]         status_o;
  logic [3:0]         box_index_o;
  logic signed [31:0] read_data_o;
  logic [6:0]         queued_o;
  logic               arrived_flag_o;

  int mismatch_count;
  int words_pending;
  int quiet_cycles = 0;
  int n_issued     = 0;
  bit gaps_on      = 1'b1;

  always #5 clk_i = ~clk_i;

  multi_mailbox_queue_table_core dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .op_i,
    .box_i,
    .capacity_i,
    .message_i,
    .done_o,
    .status_o,
    .box_index_o,
    .read_data_o,
    .queued_o,
    .arrived_flag_o
  );

  mailbox_result_checker checker_i (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i         (busy_o),
    .op_i,
    .box_i,
    .capacity_i,
    .message_i,
    .done_i         (done_o),
    .status_i       (status_o),
    .box_index_i    (box_index_o),
    .read_data_i    (read_data_o),
    .queued_i       (queued_o),
    .arrived_flag_i (arrived_flag_o),
    .errors_o       (mismatch_count),
    .outstanding_o  (words_pending)
  );

  // End the run if neither side moves a word for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one command word and hold it until the block takes it
  task automatic issue_cmd(input op_e op, input logic [3:0] bx, input logic [6:0] cap,
                           input logic [31:0] msg);
    logic taken;
    while (gaps_on && $urandom_range(99) < 22) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    op_i       <= op;
    box_i      <= bx;
    capacity_i <= cap;
    message_i  <= msg;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end
    n_issued++;
  endtask

  // Mostly small queues, a few deep ones, some refused sizes
  function automatic logic [6:0] pick_capacity();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return 7'($urandom_range(1, 8));
    if (r < 88) return 7'($urandom_range(9, BOX_DEPTH));
    if (r < 92) return 7'd0;
    return 7'($urandom_range(BOX_DEPTH + 1, 127));
  endfunction

  initial begin
    int unsigned sel;
    int unsigned len;
    logic [3:0]  bx;
    op_e         op;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Refused sizes, then boxes 1 and 2 from a fresh search pointer
    issue_cmd(OP_ALLOC, 4'd5, 7'd0, 32'h0);
    issue_cmd(OP_ALLOC, 4'd0, 7'd65, 32'hffff_ffff);
    issue_cmd(OP_ALLOC, 4'd15, 7'd127, 32'h0);
    issue_cmd(OP_ALLOC, 4'd0, 7'd64, 32'h0);
    issue_cmd(OP_ALLOC, 4'd0, 7'd1, 32'h0);
    // Single-entry box: fill, overflow, drain, underflow
    issue_cmd(OP_SEND, 4'd2, 7'd0, 32'h7fff_ffff);
    issue_cmd(OP_SEND, 4'd2, 7'd0, 32'h1234_5678);
    issue_cmd(OP_RECV, 4'd2, 7'd0, 32'h0);
    issue_cmd(OP_RECV, 4'd2, 7'd0, 32'h0);
    // Operations on free boxes, and freeing box 2 before a receive from it
    issue_cmd(OP_SEND, 4'd0, 7'd0, 32'h5555_aaaa);
    issue_cmd(OP_RECV, 4'd15, 7'd127, 32'h0);
    issue_cmd(OP_FREE, 4'd0, 7'd0, 32'h0);
    issue_cmd(OP_FREE, 4'd2, 7'd0, 32'h0);
    issue_cmd(OP_RECV, 4'd2, 7'd0, 32'h0);
    // Three-entry box with a wrapped tail and head
    issue_cmd(OP_ALLOC, 4'd9, 7'd3, 32'h0);
    issue_cmd(OP_SEND, 4'd3, 7'd0, 32'h8000_0000);
    issue_cmd(OP_SEND, 4'd3, 7'd0, 32'hffff_ffff);
    issue_cmd(OP_SEND, 4'd3, 7'd0, 32'h0000_0000);
    issue_cmd(OP_RECV, 4'd3, 7'd0, 32'h0);
    issue_cmd(OP_RECV, 4'd3, 7'd0, 32'h0);
    issue_cmd(OP_SEND, 4'd3, 7'd0, 32'h0000_0001);
    issue_cmd(OP_SEND, 4'd3, 7'd0, 32'hdead_beef);
    repeat (4) issue_cmd(OP_RECV, 4'd3, 7'd0, 32'h0);

    // Fill the deepest box past full, then drain it past empty
    repeat (BOX_DEPTH + 2) issue_cmd(OP_SEND, 4'd1, 7'($urandom), $urandom);
    repeat (BOX_DEPTH + 2) issue_cmd(OP_RECV, 4'd1, 7'($urandom), $urandom);

    // Fill the table so that most random commands hit live boxes
    repeat (NUM_BOXES + 2) issue_cmd(OP_ALLOC, 4'($urandom), pick_capacity(), $urandom);

    while (n_issued < ITEMS) begin
      gaps_on = !(n_issued >= 450 && n_issued < 650);
      sel = $urandom_range(99);
      if (sel < 10) begin
        bx  = 4'($urandom_range(15));
        len = $urandom_range(1, 12);
        repeat (len) issue_cmd(OP_SEND, bx, 7'($urandom), $urandom);
        repeat (len) issue_cmd(OP_RECV, bx, 7'($urandom), $urandom);
      end else begin
        sel = $urandom_range(99);
        if (sel < 15)      op = OP_ALLOC;
        else if (sel < 55) op = OP_SEND;
        else if (sel < 90) op = OP_RECV;
        else               op = OP_FREE;
        issue_cmd(op, 4'($urandom_range(15)),
                  (op == OP_ALLOC) ? pick_capacity() : 7'($urandom), $urandom);
      end
    end
    start_i <= 1'b0;

    while (words_pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
